/* sv/vtt_pkg.sv */
`default_nettype none
package vtt_pkg;

  localparam int NumTimersDef = 16;
  localparam int PaddrW       = 3;

  localparam logic [19:0] TicksPerMsRst = 20'd1000;
  localparam logic [31:0] SlackTicksRst = 32'd10000;

  // register index, taken from paddr[2]
  localparam logic RegTicksPerMs = 1'b0;
  localparam logic RegSlackTicks = 1'b1;

  localparam logic KindReply = 1'b0;
  localparam logic KindFired = 1'b1;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } vtt_op_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NO_FREE  = 3'd1,
    STS_BAD_ID   = 3'd2,
    STS_EXPIRED  = 3'd3,
    STS_OVERFLOW = 3'd4
  } vtt_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_MUL,
    S_START_ADD,
    S_CAN_CHK,
    S_CAN_EV,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SCAN_MUL,
    S_SCAN_ADD,
    S_REPLY
  } vtt_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] now;
    logic [31:0] delay_ms;
    logic        periodic;
    logic [5:0]  target_id;
  } vtt_req_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [5:0]  slot_id;
    logic        compare_valid;
    logic [31:0] compare_value;
    logic        last;
  } vtt_res_t;

endpackage
`default_nettype wire

/* sv/vtt_cfg.sv */
`default_nettype none
module vtt_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel_i,
  input  wire logic                      penable_i,
  input  wire logic                      pwrite_i,
  input  wire logic [vtt_pkg::PaddrW-1:0] paddr_i,
  input  wire logic [31:0]               pwdata_i,
  output logic      [31:0]               prdata_o,
  output logic      [19:0]               ticks_per_ms_o,
  output logic      [31:0]               slack_ticks_o
);
  import vtt_pkg::*;

  logic [19:0] tpm_q, tpm_d;
  logic [31:0] slack_q, slack_d;
  logic        wr_en;

  assign wr_en = psel_i && penable_i && pwrite_i;

  always_comb begin
    tpm_d   = tpm_q;
    slack_d = slack_q;
    if (wr_en) begin
      unique case (paddr_i[2])
        RegTicksPerMs: tpm_d   = pwdata_i[19:0];
        RegSlackTicks: slack_d = pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      RegTicksPerMs: prdata_o = {12'b0, tpm_q};
      RegSlackTicks: prdata_o = slack_q;
      default:       prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q   <= TicksPerMsRst;
      slack_q <= SlackTicksRst;
    end else begin
      tpm_q   <= tpm_d;
      slack_q <= slack_d;
    end
  end

  assign ticks_per_ms_o = tpm_q;
  assign slack_ticks_o  = slack_q;

endmodule
`default_nettype wire

/* sv/vtt_mem.sv */
`default_nettype none
module vtt_mem #(
  parameter int Depth = vtt_pkg::NumTimersDef,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             we_per_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [63:0]      wdl_i,
  input  wire logic [31:0]      wper_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [63:0]      rdl_o,
  output logic      [31:0]      rper_o
);

  logic [63:0] dl_mem  [Depth];
  logic [31:0] per_mem [Depth];
  logic [63:0] rdl_q;
  logic [31:0] rper_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dl_mem[waddr_i] <= wdl_i;
    end
    if (we_i && we_per_i) begin
      per_mem[waddr_i] <= wper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdl_q  <= dl_mem[raddr_i];
      rper_q <= per_mem[raddr_i];
    end
  end

  assign rdl_o  = rdl_q;
  assign rper_o = rper_q;

endmodule
`default_nettype wire

/* sv/virtual_timer_table.sv */
// Sequence: a start passes START_MUL and START_ADD, a cancel CAN_CHK and CAN_EV,
//   before the slot scan (a failing one skips it), a tick none; the scan reads each
//   slot in SCAN_RD and SCAN_EV, plus SCAN_MUL and SCAN_ADD per periodic timer that
//   fires, through the single read port of the deadline memory, and ends in REPLY.
// Requests: one at a time; output stalls hold the scan and the reply.
// Reset: asynchronous; clears control state, slot flags and registers, not the memory.
`default_nettype none
module virtual_timer_table #(
  parameter int NUM_TIMERS = vtt_pkg::NumTimersDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire vtt_pkg::vtt_req_t          in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output vtt_pkg::vtt_res_t               out_res_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [vtt_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import vtt_pkg::*;

  localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [19:0] tpm;
  logic [31:0] slack;

  vtt_state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  vtt_req_t        req_q, req_d;
  logic [51:0]     prod_q, prod_d;
  logic [63:0]     best_q, best_d;
  logic            any_q, any_d;
  logic            le_q, le_d;
  vtt_status_e     rep_status_q, rep_status_d;
  logic [5:0]      rep_slot_q, rep_slot_d;
  logic [NUM_TIMERS-1:0] act_q, act_d;
  logic [NUM_TIMERS-1:0] per_q, per_d;
  logic            out_valid_q, out_valid_d;
  vtt_res_t        out_q, out_d;

  logic            mem_we, mem_we_per, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [63:0]     mem_wdl, rd_dl;
  logic [31:0]     rd_per, mul_b;

  logic [51:0]     mul;
  logic [64:0]     sum;
  logic [63:0]     sat;
  logic            emit_ok;
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  logic [IdxW-1:0] tid_idx;
  logic            tid_ok;
  logic            last_idx;
  logic            fire;
  vtt_state_e      nxt_state;
  logic [IdxW-1:0] nxt_idx;

  vtt_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .ticks_per_ms_o (tpm),
    .slack_ticks_o  (slack)
  );

  vtt_mem #(
    .Depth (NUM_TIMERS),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .we_per_i (mem_we_per),
    .waddr_i  (mem_waddr),
    .wdl_i    (mem_wdl),
    .wper_i   (req_q.delay_ms),
    .re_i     (mem_re),
    .raddr_i  (mem_raddr),
    .rdl_o    (rd_dl),
    .rper_o   (rd_per)
  );

  assign pready = 1'b1;

  assign mul     = {32'b0, tpm} * {20'b0, mul_b};
  assign sum     = {1'b0, req_q.now} + {13'b0, prod_q};
  assign sat     = sum[64] ? '1 : sum[63:0];
  assign emit_ok = !out_valid_q || !out_stall_i;

  assign tid_idx  = req_q.target_id[IdxW-1:0];
  assign tid_ok   = ({1'b0, req_q.target_id} < 7'(NUM_TIMERS)) && act_q[tid_idx];
  assign last_idx = (idx_q == IdxW'(NUM_TIMERS - 1));
  assign fire     = act_q[idx_q] && (le_q ? (rd_dl <= req_q.now) : (rd_dl < req_q.now));
  assign nxt_state = last_idx ? S_REPLY : S_SCAN_RD;
  assign nxt_idx   = last_idx ? idx_q : idx_q + IdxW'(1);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    req_d        = req_q;
    prod_d       = prod_q;
    best_d       = best_q;
    any_d        = any_q;
    le_d         = le_q;
    rep_status_d = rep_status_q;
    rep_slot_d   = rep_slot_q;
    act_d        = act_q;
    per_d        = per_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_we_per   = 1'b0;
    mem_waddr    = idx_q;
    mem_wdl      = sat;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;
    mul_b        = rd_per;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_req_i;
          any_d        = 1'b0;
          idx_d        = '0;
          rep_status_d = STS_OK;
          rep_slot_d   = '0;
          le_d         = (in_req_i.operation == OP_TICK);
          unique case (in_req_i.operation)
            OP_START:  state_d = S_START_MUL;
            OP_CANCEL: state_d = S_CAN_CHK;
            OP_TICK:   state_d = S_SCAN_RD;
            default:   state_d = S_REPLY;
          endcase
        end
      end
      S_START_MUL: begin
        mul_b   = req_q.delay_ms;
        prod_d  = mul;
        state_d = S_START_ADD;
      end
      S_START_ADD: begin
        if (!free_found) begin
          rep_status_d = STS_NO_FREE;
          state_d      = S_REPLY;
        end else if (sum[64]) begin
          rep_status_d = STS_OVERFLOW;
          state_d      = S_REPLY;
        end else begin
          mem_we          = 1'b1;
          mem_we_per      = 1'b1;
          mem_waddr       = free_idx;
          mem_wdl         = sum[63:0];
          act_d[free_idx] = 1'b1;
          per_d[free_idx] = req_q.periodic;
          rep_slot_d      = 6'(free_idx);
          state_d         = S_SCAN_RD;
        end
      end
      S_CAN_CHK: begin
        rep_slot_d = req_q.target_id;
        if (!tid_ok) begin
          rep_status_d = STS_BAD_ID;
          state_d      = S_REPLY;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = tid_idx;
          state_d   = S_CAN_EV;
        end
      end
      S_CAN_EV: begin
        act_d[tid_idx] = 1'b0;
        if (rd_dl < req_q.now) begin
          rep_status_d = STS_EXPIRED;
          state_d      = S_REPLY;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        mem_re  = 1'b1;
        state_d = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (fire) begin
          if (emit_ok) begin
            out_valid_d   = 1'b1;
            out_d         = '0;
            out_d.kind    = KindFired;
            out_d.slot_id = 6'(idx_q);
            if (per_q[idx_q]) begin
              state_d = S_SCAN_MUL;
            end else begin
              act_d[idx_q] = 1'b0;
              state_d      = nxt_state;
              idx_d        = nxt_idx;
            end
          end
        end else begin
          if (act_q[idx_q] && (!any_q || rd_dl < best_q)) begin
            best_d = rd_dl;
            any_d  = 1'b1;
          end
          state_d = nxt_state;
          idx_d   = nxt_idx;
        end
      end
      S_SCAN_MUL: begin
        prod_d  = mul;
        state_d = S_SCAN_ADD;
      end
      S_SCAN_ADD: begin
        mem_we = 1'b1;
        if (!any_q || sat < best_q) begin
          best_d = sat;
          any_d  = 1'b1;
        end
        state_d = nxt_state;
        idx_d   = nxt_idx;
      end
      S_REPLY: begin
        if (emit_ok) begin
          out_valid_d         = 1'b1;
          out_d               = '0;
          out_d.kind          = KindReply;
          out_d.status        = rep_status_q;
          out_d.slot_id       = rep_slot_q;
          out_d.compare_valid = any_q;
          out_d.compare_value = any_q ? best_q[31:0] + slack : '0;
          out_d.last          = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      any_q       <= 1'b0;
      le_q        <= 1'b0;
      act_q       <= '0;
      per_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      any_q       <= any_d;
      le_q        <= le_d;
      act_q       <= act_d;
      per_q       <= per_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    prod_q       <= prod_d;
    best_q       <= best_d;
    rep_status_q <= rep_status_d;
    rep_slot_q   <= rep_slot_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule
`default_nettype wire

/* sv/vtt_chk.sv */
`default_nettype none
module vtt_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire vtt_pkg::vtt_res_t out_res_o
);
  import vtt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_fired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.kind == KindFired) |->
      !out_res_o.last && (out_res_o.status == STS_OK) && !out_res_o.compare_valid)
    else $error("fired event malformed");

  a_cmp_on_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.compare_valid |->
      out_res_o.last && (out_res_o.kind == KindReply))
    else $error("compare value outside final reply");

  a_err_no_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.status != STS_OK) |-> !out_res_o.compare_valid)
    else $error("error reply carries compare value");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous in flight");

endmodule

bind virtual_timer_table vtt_chk u_vtt_chk (.*);
`default_nettype wire

/* tb/vtt_checker.sv */
module vtt_checker
  import vtt_pkg::*;
#(
  parameter int NUM_TIMERS = NumTimersDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  vtt_req_t          in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  vtt_res_t          out_res_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [PaddrW-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic [31:0]       prdata_i,
  input  logic              pready_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                results_o,
  output int                fired_o
);

  logic        armed     [NUM_TIMERS];
  logic        repeating [NUM_TIMERS];
  logic [63:0] due       [NUM_TIMERS];
  logic [31:0] period_ms [NUM_TIMERS];
  logic [19:0] ticks_per_ms;
  logic [31:0] slack_ticks;
  vtt_res_t    expected_q [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic expect_res(input logic kind, input logic [2:0] status,
                            input logic [5:0] slot, input logic cv,
                            input logic [31:0] cval);
    vtt_res_t r;
    r.kind          = kind;
    r.status        = status;
    r.slot_id       = slot;
    r.compare_valid = cv;
    r.compare_value = cval;
    r.last          = (kind == KindReply);
    expected_q.push_back(r);
  endtask

  // 65 bits so that bit 64 flags a wrap
  function automatic logic [64:0] deadline_after(input logic [63:0] now,
                                                 input logic [31:0] ms);
    return {1'b0, now} + 65'(ticks_per_ms) * 65'(ms);
  endfunction

  task automatic fire_slot(input int i, input logic [63:0] now);
    logic [64:0] next;
    next = deadline_after(now, period_ms[i]);
    expect_res(KindFired, STS_OK, 6'(i), 1'b0, '0);
    if (repeating[i]) begin
      due[i] = next[64] ? '1 : next[63:0];
    end else begin
      armed[i] = 1'b0;
    end
  endtask

  task automatic rescan(input logic [63:0] now, output logic cv,
                        output logic [31:0] cval);
    logic [63:0] best;
    best = '0;
    cv   = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (armed[i] && due[i] < now) fire_slot(i, now);
    end
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (armed[i] && (!cv || due[i] < best)) begin
        best = due[i];
        cv   = 1'b1;
      end
    end
    cval = cv ? best[31:0] + slack_ticks : '0;
  endtask

  task automatic predict(input vtt_req_t req);
    logic        cv;
    logic [31:0] cval;
    logic [64:0] dl;
    int          slot;
    cv   = 1'b0;
    cval = '0;
    slot = -1;
    case (vtt_op_e'(req.operation))
      OP_START: begin
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
          if (!armed[i]) slot = i;
        end
        dl = deadline_after(req.now, req.delay_ms);
        if (slot < 0) begin
          expect_res(KindReply, STS_NO_FREE, '0, 1'b0, '0);
        end else if (dl[64]) begin
          expect_res(KindReply, STS_OVERFLOW, '0, 1'b0, '0);
        end else begin
          armed[slot]     = 1'b1;
          repeating[slot] = req.periodic;
          due[slot]       = dl[63:0];
          period_ms[slot] = req.delay_ms;
          rescan(req.now, cv, cval);
          expect_res(KindReply, STS_OK, 6'(slot), cv, cval);
        end
      end
      OP_CANCEL: begin
        if (req.target_id >= NUM_TIMERS || !armed[req.target_id]) begin
          expect_res(KindReply, STS_BAD_ID, req.target_id, 1'b0, '0);
        end else begin
          armed[req.target_id] = 1'b0;
          if (due[req.target_id] < req.now) begin
            expect_res(KindReply, STS_EXPIRED, req.target_id, 1'b0, '0);
          end else begin
            rescan(req.now, cv, cval);
            expect_res(KindReply, STS_OK, req.target_id, cv, cval);
          end
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (armed[i] && due[i] <= req.now) fire_slot(i, req.now);
        end
        rescan(req.now, cv, cval);
        expect_res(KindReply, STS_OK, '0, cv, cval);
      end
      default: begin
        expect_res(KindReply, STS_OK, '0, 1'b0, '0);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vtt_res_t want;
    if (!rst_ni) begin
      ticks_per_ms = TicksPerMsRst;
      slack_ticks  = SlackTicksRst;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        armed[i]     = 1'b0;
        repeating[i] = 1'b0;
      end
      expected_q.delete();
      fail_count_o = 0;
      results_o    = 0;
      fired_o      = 0;
      pending_o    = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[PaddrW-1] == RegTicksPerMs) ticks_per_ms = pwdata_i[19:0];
          else slack_ticks = pwdata_i;
        end else begin
          check_field("register read", prdata_i,
                      paddr_i[PaddrW-1] == RegTicksPerMs ? 32'(ticks_per_ms) : slack_ticks);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (out_res_i.kind == KindFired) fired_o++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing outstanding", out_res_i));
        end else begin
          want = expected_q.pop_front();
          check_field("kind", out_res_i.kind, want.kind);
          check_field("status", out_res_i.status, want.status);
          check_field("slot_id", out_res_i.slot_id, want.slot_id);
          check_field("compare_valid", out_res_i.compare_valid, want.compare_valid);
          check_field("compare_value", out_res_i.compare_value, want.compare_value);
          check_field("last", out_res_i.last, want.last);
        end
      end
      if (in_valid_i && !in_stall_i) predict(in_req_i);
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  import vtt_pkg::*;

  localparam int NumTimers   = NumTimersDef;
  localparam int NumPhases   = 6;
  localparam int PhaseItems  = 55;
  localparam int LongHold    = 400;
  localparam int LimitCycles = 1_500_000;

  localparam logic [PaddrW-1:0] AddrTicksPerMs = {RegTicksPerMs, 2'b00};
  localparam logic [PaddrW-1:0] AddrSlackTicks = {RegSlackTicks, 2'b00};

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  vtt_req_t          in_req    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  vtt_res_t          out_res;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [PaddrW-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  int          fail_count;
  int          pending;
  int          results_seen;
  int          fired_seen;
  int          long_hold = 0;
  int          sent      = 0;
  logic [19:0] ticks_now = TicksPerMsRst;
  logic [63:0] clock_now = '0;

  virtual_timer_table #(.NUM_TIMERS(NumTimers)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  vtt_checker #(.NUM_TIMERS(NumTimers)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_res_i   (out_res),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results_seen),
    .fired_o     (fired_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic vtt_req_t make_req(input vtt_op_e op, input logic [63:0] now,
                                        input logic [31:0] delay, input logic per,
                                        input logic [5:0] tid);
    vtt_req_t r;
    r.operation = op;
    r.now       = now;
    r.delay_ms  = delay;
    r.periodic  = per;
    r.target_id = tid;
    return r;
  endfunction

  // valid stays high across back-to-back requests
  task automatic send(input vtt_req_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [PaddrW-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [19:0] ticks, input logic [31:0] slack);
    reg_access(1'b1, AddrTicksPerMs, {12'($urandom), ticks});
    reg_access(1'b1, AddrSlackTicks, slack);
    reg_access(1'b0, AddrTicksPerMs, '0);
    reg_access(1'b0, AddrSlackTicks, '0);
    ticks_now = ticks;
  endtask

  // mostly a monotonic counter with short delays; some noise requests
  task automatic random_request();
    int pick;
    clock_now += 64'(ticks_now) * $urandom_range(0, 6) + $urandom_range(0, 3);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send(make_req(OP_START, clock_now, 32'($urandom_range(0, 12)),
                    $urandom_range(0, 3) == 0, '0));
    end else if (pick < 60) begin
      send(make_req(OP_CANCEL, clock_now, '0, 1'b0,
                    6'($urandom_range(0, NumTimers - 1))));
    end else if (pick < 88) begin
      send(make_req(OP_TICK, clock_now, '0, 1'b0, '0));
    end else begin
      send(make_req(vtt_op_e'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom,
                    1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))));
    end
  endtask

  initial begin
    int n;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold != 0 && !hold_done) begin
        n         = long_hold;
        hold_done = 1'b1;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(make_req(OP_TICK, '0, '0, 1'b0, '0));
    send(make_req(OP_NONE, {$urandom, $urandom}, $urandom, 1'b1, 6'd63));
    send(make_req(OP_START, 64'd100, 32'd0, 1'b0, '0));
    send(make_req(OP_START, 64'd200, 32'd5, 1'b1, '0));
    send(make_req(OP_START, '1, 32'd1, 1'b0, '0));
    // fires the periodic timer that is still armed; it saturates on re-arm
    send(make_req(OP_START, '1, 32'd0, 1'b0, '0));
    send(make_req(OP_CANCEL, '0, '0, 1'b0, 6'd63));
    send(make_req(OP_CANCEL, '0, '0, 1'b0, 6'(NumTimers)));
    send(make_req(OP_TICK, '1, '0, 1'b0, '0));
    send(make_req(OP_START, 64'd1000, 32'd1, 1'b0, '0));
    send(make_req(OP_CANCEL, 64'd5000, '0, 1'b0, 6'd0));
    send(make_req(OP_START, '0, 32'd10, 1'b0, '0));
    send(make_req(OP_CANCEL, '0, '0, 1'b0, 6'd0));
    // fill the table; the last start finds no free slot
    for (int i = 0; i < NumTimers; i++) begin
      send(make_req(OP_START, '0, 32'($urandom_range(0, 3)), i[0], '0));
    end
    send(make_req(OP_TICK, '1, '0, 1'b0, '0));
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: set_regs(20'd1, 32'd0);
        2: set_regs('1, '1);
        3: set_regs(20'd0, $urandom);
        4: set_regs(20'd1000000, $urandom);
        5: begin
          set_regs(20'($urandom_range(1, 5000)), $urandom);
          clock_now = '1 - 64'd300000;
        end
        default: ;
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        if (ph == 2 && k == 10) long_hold = LongHold;
        random_request();
      end
      wait_idle();
    end
    repeat (40) @(posedge clk_i);

    $display("Covered %0d requests under %0d register settings, with long output back-pressure.",
             sent, NumPhases);
    $display("Compared %0d results, %0d of them timer events.", results_seen, fired_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(LimitCycles * 10);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
sv/vtt_pkg.sv
sv/vtt_cfg.sv
sv/vtt_mem.sv
sv/virtual_timer_table.sv
sv/vtt_chk.sv
tb/vtt_checker.sv
tb/tb_top.sv
